// ===== hdl/cawb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, sizes and codes for the counter add write buffer.
package cawb_pkg;

	localparam int BUF_DEPTH = 64;
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
	localparam int IDX_W     = $clog2(BUF_DEPTH);
	// two banks: one fills while the other drains
	localparam int RAM_DEPTH = 2 * BUF_DEPTH;
	localparam int RAM_AW    = IDX_W + 1;

	localparam int ADDR_W    = 32;
	localparam int OPND_W    = 64;
	localparam int ENTRY_W   = ADDR_W + OPND_W;
	localparam int IN_DATA_W = 104;
	localparam int KIND_W    = 2;
	localparam int THR_W     = 7;
	localparam int HINT_W    = 8;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;
	localparam int Q_DEPTH   = 2;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	localparam int THR_RESET  = 32;
	localparam int HINT_RESET = 64;

	typedef enum logic [KIND_W-1:0] {
		KIND_SCHED = 2'd0,
		KIND_HINT  = 2'd1,
		KIND_TRY   = 2'd2,
		KIND_FORCE = 2'd3
	} kind_t;

	localparam logic [CFG_IDX_W-1:0] REG_SOFT_THR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HINT_LIM = 1'b1;

	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] count;
	} drain_cmd_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} bank_done_t;

	typedef struct packed {
		logic               we;
		logic [RAM_AW-1:0]  addr;
		logic [ENTRY_W-1:0] data;
	} ram_wr_t;

endpackage

// ===== hdl/cawb_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module cawb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/cawb_front.sv =====
`timescale 1ns / 1ps
// Front end: takes items, keeps pending count and hint count, decides drains.
module cawb_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [cawb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cawb_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_tvalid,
	output logic                                 in_tready,
	input  logic [cawb_pkg::IN_DATA_W-1:0]       in_tdata,
	input  logic [cawb_pkg::KIND_W-1:0]          in_tuser,
	input  cawb_pkg::bank_done_t                 done,
	output logic                                 push,
	output cawb_pkg::drain_cmd_t                 push_cmd,
	output cawb_pkg::ram_wr_t                    ram_wr
);

	logic [cawb_pkg::THR_W-1:0]  soft_thr_q;
	logic [cawb_pkg::HINT_W-1:0] hint_lim_q;
	logic [cawb_pkg::CNT_W-1:0]  pend_cnt_q;
	logic [cawb_pkg::HINT_W-1:0] hint_cnt_q;
	logic                        cur_q;
	logic [1:0]                  busy_q;

	cawb_pkg::kind_t              kind;
	logic [cawb_pkg::ADDR_W-1:0]  addr;
	logic [cawb_pkg::OPND_W-1:0]  opnd;
	logic                         lock_free;
	logic                         full;
	logic                         nonempty;
	logic                         sched;
	logic                         drain_go;
	logic                         hint_bump;
	logic                         accept;
	logic                         wr_bank;
	logic [cawb_pkg::IDX_W-1:0]   wr_idx;

	assign kind      = cawb_pkg::kind_t'(in_tuser);
	assign addr      = in_tdata[cawb_pkg::ADDR_W-1:0];
	assign opnd      = in_tdata[cawb_pkg::ENTRY_W-1:cawb_pkg::ADDR_W];
	assign lock_free = in_tdata[cawb_pkg::ENTRY_W];
	assign full      = pend_cnt_q == cawb_pkg::CNT_W'(cawb_pkg::BUF_DEPTH);
	assign nonempty  = pend_cnt_q != '0;
	assign sched     = kind == cawb_pkg::KIND_SCHED;

	always_comb begin
		drain_go  = 1'b0;
		hint_bump = 1'b0;
		case (kind)
			cawb_pkg::KIND_SCHED: begin
				drain_go = full || ((pend_cnt_q > soft_thr_q) && lock_free);
			end
			cawb_pkg::KIND_HINT: begin
				if (hint_cnt_q == hint_lim_q) begin
					drain_go = full || lock_free;
				end else begin
					hint_bump = 1'b1;
				end
			end
			cawb_pkg::KIND_TRY: begin
				drain_go = full || lock_free;
			end
			cawb_pkg::KIND_FORCE: begin
				drain_go = 1'b1;
			end
			default: begin
				drain_go = 1'b0;
			end
		endcase
	end

	// a schedule that drains writes straight into the other bank, so that one must be free
	assign in_tready = !busy_q[cur_q] && !(sched && drain_go && busy_q[~cur_q]);
	assign accept    = in_tvalid && in_tready;
	assign push      = accept && drain_go && nonempty;
	assign push_cmd  = '{bank: cur_q, count: pend_cnt_q};

	assign wr_bank     = (drain_go && nonempty) ? ~cur_q : cur_q;
	assign wr_idx      = drain_go ? '0 : pend_cnt_q[cawb_pkg::IDX_W-1:0];
	assign ram_wr.we   = accept && sched;
	assign ram_wr.addr = {wr_bank, wr_idx};
	assign ram_wr.data = {opnd, addr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soft_thr_q <= cawb_pkg::THR_W'(cawb_pkg::THR_RESET);
			hint_lim_q <= cawb_pkg::HINT_W'(cawb_pkg::HINT_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				cawb_pkg::REG_SOFT_THR: soft_thr_q <= cfg_data[cawb_pkg::THR_W-1:0];
				cawb_pkg::REG_HINT_LIM: hint_lim_q <= cfg_data[cawb_pkg::HINT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= '0;
			hint_cnt_q <= '0;
			cur_q      <= 1'b0;
			busy_q     <= '0;
		end else begin
			if (done.valid) begin
				busy_q[done.bank] <= 1'b0;
			end
			if (push) begin
				busy_q[cur_q] <= 1'b1;
				cur_q         <= ~cur_q;
			end
			if (accept) begin
				if (drain_go) begin
					pend_cnt_q <= sched ? cawb_pkg::CNT_W'(1) : '0;
					hint_cnt_q <= '0;
				end else begin
					if (sched) begin
						pend_cnt_q <= pend_cnt_q + cawb_pkg::CNT_W'(1);
					end
					if (hint_bump) begin
						hint_cnt_q <= hint_cnt_q + cawb_pkg::HINT_W'(1);
					end
				end
			end
		end
	end

endmodule

// ===== hdl/cawb_queue.sv =====
`timescale 1ns / 1ps
// Short queue of drain commands between front and back.
module cawb_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cawb_pkg::drain_cmd_t push_cmd,
	input  logic                 pop,
	output logic                 head_valid,
	output cawb_pkg::drain_cmd_t head_cmd
);

	cawb_pkg::drain_cmd_t            slot_q [cawb_pkg::Q_DEPTH];
	logic [cawb_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [cawb_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [cawb_pkg::Q_CNT_W-1:0]    cnt_q;

	assign head_valid = cnt_q != '0;
	assign head_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// at most two drains are ever outstanding, so the queue cannot overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + cawb_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + cawb_pkg::Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + cawb_pkg::Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - cawb_pkg::Q_CNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/cawb_back.sv =====
`timescale 1ns / 1ps
// Back end: walks one bank of the buffer and streams its entries out.
module cawb_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  cawb_pkg::drain_cmd_t          cmd,
	output logic                          cmd_pop,
	output cawb_pkg::bank_done_t          done,
	output logic                          ram_re,
	output logic [cawb_pkg::RAM_AW-1:0]   ram_raddr,
	output logic                          out_tvalid,
	input  logic                          out_tready,
	output logic                          out_tlast
);

	logic                       active_q;
	logic                       bank_q;
	logic [cawb_pkg::IDX_W-1:0] idx_q;
	logic [cawb_pkg::CNT_W-1:0] cnt_q;
	logic                       valid_q;
	logic                       last_q;
	logic                       issue;
	logic                       is_last;

	assign cmd_pop = !active_q && cmd_valid;
	// RAM read register doubles as the output register
	assign issue   = active_q && (!valid_q || out_tready);
	assign is_last = (cawb_pkg::CNT_W'(idx_q) + cawb_pkg::CNT_W'(1)) == cnt_q;

	assign ram_re     = issue;
	assign ram_raddr  = {bank_q, idx_q};
	assign done.valid = issue && is_last;
	assign done.bank  = bank_q;
	assign out_tvalid = valid_q;
	assign out_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			bank_q   <= 1'b0;
			idx_q    <= '0;
			cnt_q    <= '0;
			valid_q  <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			if (cmd_pop) begin
				active_q <= 1'b1;
				bank_q   <= cmd.bank;
				cnt_q    <= cmd.count;
				idx_q    <= '0;
			end else if (issue) begin
				idx_q <= idx_q + cawb_pkg::IDX_W'(1);
				if (is_last) begin
					active_q <= 1'b0;
				end
			end
			if (issue) begin
				valid_q <= 1'b1;
				last_q  <= is_last;
			end else if (out_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/counter_add_write_buffer_top.sv =====
`timescale 1ns / 1ps
// Usage: batched write buffer that collects counter adds and drains them as bursts.
// Input stream: in_tuser carries the kind (schedule, hint, try flush, forced
// flush); in_tdata carries counter address, operand and the lock-free flag.
// Output stream: one transfer per drained entry, address and operand in
// out_tdata, out_tlast on the final entry of a drain. Empty drains send nothing.
// Config: cfg_we writes soft threshold (index 0) or hint limit (index 1);
// write only while the block is idle.
// Throughput: one item per cycle while no bank conflict exists. The buffer has
// two banks, so new schedules fill one bank while the back end streams the other.
// An item stalls only while its bank still drains (or, for a schedule that
// drains, while the other bank still drains).
// With the back end idle, a drain command passes through the queue to the back end,
// whose first RAM read fills the output register; the entries then follow one per
// cycle while out_tready stays high, limited by the single RAM read port.
// A stall on out_tready holds the output and pauses the RAM walk; input keeps
// flowing into the filling bank. Reset clears counts, the queue and the output;
// buffer contents need no clearing.
module counter_add_write_buffer_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [cawb_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [cawb_pkg::CFG_W-1:0]             cfg_data,
	input  logic                                   in_tvalid,
	output logic                                   in_tready,
	// [31:0] counter_address, [95:32] operand, [96] lock_free, [103:97] zero
	input  logic [cawb_pkg::IN_DATA_W-1:0]         in_tdata,
	// [1:0] kind
	input  logic [cawb_pkg::KIND_W-1:0]            in_tuser,
	output logic                                   out_tvalid,
	input  logic                                   out_tready,
	// [31:0] target_address, [95:32] add_value
	output logic [cawb_pkg::ENTRY_W-1:0]           out_tdata,
	output logic                                   out_tlast
);

	logic                          push;
	cawb_pkg::drain_cmd_t          push_cmd;
	cawb_pkg::ram_wr_t             ram_wr;
	cawb_pkg::bank_done_t          done;
	logic                          head_valid;
	cawb_pkg::drain_cmd_t          head_cmd;
	logic                          cmd_pop;
	logic                          ram_re;
	logic [cawb_pkg::RAM_AW-1:0]   ram_raddr;

	cawb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_tvalid (in_tvalid),
		.in_tready (in_tready),
		.in_tdata  (in_tdata),
		.in_tuser  (in_tuser),
		.done      (done),
		.push      (push),
		.push_cmd  (push_cmd),
		.ram_wr    (ram_wr)
	);

	cawb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (cmd_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	cawb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (head_valid),
		.cmd        (head_cmd),
		.cmd_pop    (cmd_pop),
		.done       (done),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.out_tvalid (out_tvalid),
		.out_tready (out_tready),
		.out_tlast  (out_tlast)
	);

	cawb_ram #(
		.WIDTH (cawb_pkg::ENTRY_W),
		.DEPTH (cawb_pkg::RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_wr.we),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (out_tdata)
	);

endmodule

// ===== hdl/cawb_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the write buffer top, attached by bind.
module cawb_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_tready,
	input logic                            out_tvalid,
	input logic                            out_tready,
	input logic [cawb_pkg::ENTRY_W-1:0]    out_tdata,
	input logic                            out_tlast
);

	// stalled output transfer stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && !out_tready |=> out_tvalid)
		else $error("out_tvalid dropped while stalled");

	// stalled output payload does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
		else $error("output payload changed while stalled");

	// input back-pressure only comes from a pending drain, which starts streaming soon
	a_stall_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!in_tready && !out_tvalid |-> ##[1:2] out_tvalid)
		else $error("input stalled with no drain in progress");

	// reset leaves nothing to send
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_tvalid || arst_n)
		else $error("output valid during reset");

endmodule

bind counter_add_write_buffer_top cawb_checker u_cawb_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the counter add write buffer: predicted drain bursts vs. output.
module tb_top;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 16;

	typedef struct {
		logic [cawb_pkg::ADDR_W-1:0] addr;
		logic [cawb_pkg::OPND_W-1:0] value;
		logic                        last;
	} add_cmd_t;

	class drain_scoreboard;
		logic [cawb_pkg::ADDR_W-1:0] addr_buf [cawb_pkg::BUF_DEPTH];
		logic [cawb_pkg::OPND_W-1:0] opnd_buf [cawb_pkg::BUF_DEPTH];
		int unsigned                 fill;
		logic [cawb_pkg::HINT_W-1:0] hints;
		logic [cawb_pkg::THR_W-1:0]  soft_thr;
		logic [cawb_pkg::HINT_W-1:0] hint_lim;
		add_cmd_t                    expected_adds[$];
		int                          errors;

		function new();
			fill = 0;
			hints = '0;
			soft_thr = cawb_pkg::THR_W'(cawb_pkg::THR_RESET);
			hint_lim = cawb_pkg::HINT_W'(cawb_pkg::HINT_RESET);
			errors = 0;
		endfunction

		function void set_regs(logic [cawb_pkg::CFG_W-1:0] thr_val,
				logic [cawb_pkg::CFG_W-1:0] lim_val);
			soft_thr = thr_val[cawb_pkg::THR_W-1:0];
			hint_lim = lim_val;
		endfunction

		function void flush_pending();
			add_cmd_t cmd;
			for (int i = 0; i < fill; i++) begin
				cmd.addr = addr_buf[i];
				cmd.value = opnd_buf[i];
				cmd.last = (i == fill - 1);
				expected_adds.push_back(cmd);
			end
			fill = 0;
			hints = '0;
		endfunction

		// a full buffer drains regardless of the lock
		function void drain_if_allowed(logic lock_free);
			if (fill >= cawb_pkg::BUF_DEPTH || lock_free)
				flush_pending();
		endfunction

		function void note_item(cawb_pkg::kind_t kind, logic [cawb_pkg::ADDR_W-1:0] addr,
				logic [cawb_pkg::OPND_W-1:0] opnd, logic lock_free);
			case (kind)
				cawb_pkg::KIND_SCHED: begin
					if (fill >= cawb_pkg::BUF_DEPTH)
						flush_pending();
					else if (fill > soft_thr)
						drain_if_allowed(lock_free);
					if (fill < cawb_pkg::BUF_DEPTH) begin
						addr_buf[fill] = addr;
						opnd_buf[fill] = opnd;
						fill++;
					end
				end
				cawb_pkg::KIND_HINT: begin
					if (hints == hint_lim)
						drain_if_allowed(lock_free);
					else
						hints = hints + 1'b1;
				end
				cawb_pkg::KIND_TRY: drain_if_allowed(lock_free);
				default: flush_pending();
			endcase
		endfunction

		function void note_failure(string msg);
			errors++;
			if (errors <= 10)
				$display("ERROR @%0t: %s", $realtime, msg);
		endfunction

		function void check_add(logic [cawb_pkg::ADDR_W-1:0] addr,
				logic [cawb_pkg::OPND_W-1:0] value, logic last);
			add_cmd_t want;
			if (expected_adds.size() == 0) begin
				note_failure($sformatf("unexpected add addr=%h value=%h last=%b",
					addr, value, last));
				return;
			end
			want = expected_adds.pop_front();
			if (addr !== want.addr || value !== want.value || last !== want.last)
				note_failure($sformatf(
					"add mismatch: exp addr=%h value=%h last=%b, got addr=%h value=%h last=%b",
					want.addr, want.value, want.last, addr, value, last));
		endfunction

		function void finish_check();
			if (expected_adds.size() != 0)
				note_failure($sformatf("%0d adds never arrived", expected_adds.size()));
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [cawb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [cawb_pkg::CFG_W-1:0]     cfg_data;
	logic                           in_tvalid;
	logic                           in_tready;
	logic [cawb_pkg::IN_DATA_W-1:0] in_tdata;
	logic [cawb_pkg::KIND_W-1:0]    in_tuser;
	logic                           out_tvalid;
	logic                           out_tready;
	logic [cawb_pkg::ENTRY_W-1:0]   out_tdata;
	logic                           out_tlast;

	drain_scoreboard sb;
	bit              idle_en;
	bit              hold_req;
	int unsigned     cycle_count;

	counter_add_write_buffer_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_tvalid  (in_tvalid),
		.in_tready  (in_tready),
		.in_tdata   (in_tdata),
		.in_tuser   (in_tuser),
		.out_tvalid (out_tvalid),
		.out_tready (out_tready),
		.out_tdata  (out_tdata),
		.out_tlast  (out_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// receiver: random back-pressure bursts, plus one long hold-off on request
	initial begin
		out_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				out_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				out_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// output transfers are sampled before the edge updates land
	always @(posedge clk) begin
		if (arst_n && out_tvalid && out_tready)
			sb.check_add(out_tdata[cawb_pkg::ADDR_W-1:0],
				out_tdata[cawb_pkg::ENTRY_W-1:cawb_pkg::ADDR_W], out_tlast);
	end

	function automatic logic [cawb_pkg::ADDR_W-1:0] pick_addr();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [cawb_pkg::OPND_W-1:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return {32'd0, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic pick_lock();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic send_item(input cawb_pkg::kind_t kind,
			input logic [cawb_pkg::ADDR_W-1:0] addr,
			input logic [cawb_pkg::OPND_W-1:0] opnd, input logic lock_free);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_tvalid <= 1'b1;
		in_tuser <= kind;
		in_tdata <= {7'd0, lock_free, opnd, addr};
		do @(posedge clk); while (!in_tready);
		sb.note_item(kind, addr, opnd, lock_free);
	endtask

	task automatic send_ctrl(input cawb_pkg::kind_t kind, input logic lock_free);
		send_item(kind, pick_addr(), pick_operand(), lock_free);
	endtask

	task automatic send_sched(input logic lock_free);
		send_item(cawb_pkg::KIND_SCHED, pick_addr(), pick_operand(), lock_free);
	endtask

	// wait for every predicted add, then let the design settle before the next phase
	task automatic settle();
		in_tvalid <= 1'b0;
		while (sb.expected_adds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [cawb_pkg::CFG_W-1:0] thr_val,
			input logic [cawb_pkg::CFG_W-1:0] lim_val);
		cfg_we <= 1'b1;
		cfg_index <= cawb_pkg::REG_SOFT_THR;
		cfg_data <= thr_val;
		@(posedge clk);
		cfg_index <= cawb_pkg::REG_HINT_LIM;
		cfg_data <= lim_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_regs(thr_val, lim_val);
	endtask

	task automatic run_random(input int n_items);
		int pick;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 62)
				send_sched(pick_lock());
			else if (pick < 77)
				send_ctrl(cawb_pkg::KIND_HINT, pick_lock());
			else if (pick < 88)
				send_ctrl(cawb_pkg::KIND_TRY, pick_lock());
			else
				send_ctrl(cawb_pkg::KIND_FORCE, pick_lock());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_tvalid <= 1'b0;
		in_tdata <= '0;
		in_tuser <= cawb_pkg::KIND_SCHED;
		sb = new();
		idle_en = 1'b1;
		hold_req = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty drains, hint limit and lock, threshold, field extremes
		program_regs(8'd3, 8'd2);
		send_ctrl(cawb_pkg::KIND_FORCE, 1'b0);
		send_ctrl(cawb_pkg::KIND_HINT, 1'b0);
		send_ctrl(cawb_pkg::KIND_HINT, 1'b1);
		send_ctrl(cawb_pkg::KIND_HINT, 1'b0);
		send_ctrl(cawb_pkg::KIND_HINT, 1'b1);
		send_item(cawb_pkg::KIND_SCHED, '0, '0, 1'b1);
		send_item(cawb_pkg::KIND_SCHED, '1, '1, 1'b0);
		send_item(cawb_pkg::KIND_SCHED, 32'h8000_0001, 64'h8000_0000_0000_0001, 1'b1);
		send_item(cawb_pkg::KIND_SCHED, 32'h5555_aaaa, 64'haaaa_5555_aaaa_5555, 1'b1);
		send_sched(1'b0);
		send_sched(1'b1);
		send_ctrl(cawb_pkg::KIND_TRY, 1'b0);
		send_ctrl(cawb_pkg::KIND_TRY, 1'b1);
		send_ctrl(cawb_pkg::KIND_TRY, 1'b1);
		send_sched(1'b0);
		send_sched(1'b1);
		send_ctrl(cawb_pkg::KIND_HINT, 1'b1);
		send_ctrl(cawb_pkg::KIND_FORCE, 1'b0);
		settle();

		// full buffer: a schedule forces the drain, then a tried drain with busy lock
		program_regs(8'd64, 8'd0);
		repeat (cawb_pkg::BUF_DEPTH) send_sched(pick_lock());
		send_sched(1'b0);
		send_ctrl(cawb_pkg::KIND_TRY, 1'b0);
		send_ctrl(cawb_pkg::KIND_FORCE, 1'b0);
		settle();

		// hint count reaches the limit, then a lower limit lets it keep counting
		program_regs(8'd64, 8'd3);
		repeat (3) send_ctrl(cawb_pkg::KIND_HINT, pick_lock());
		send_ctrl(cawb_pkg::KIND_HINT, 1'b0);
		settle();
		program_regs(8'd64, 8'd1);
		send_ctrl(cawb_pkg::KIND_HINT, 1'b1);
		send_ctrl(cawb_pkg::KIND_HINT, 1'b1);
		send_ctrl(cawb_pkg::KIND_FORCE, 1'b0);
		settle();

		// long receiver hold-off while drains pile up
		program_regs(8'd0, 8'd0);
		hold_req = 1'b1;
		run_random(20);
		settle();

		program_regs(8'd1, 8'd255);
		run_random(15);
		settle();

		program_regs(cawb_pkg::CFG_W'($urandom_range(2, 63)),
			cawb_pkg::CFG_W'($urandom_range(1, 254)));
		run_random(15);
		settle();

		program_regs(8'd64, 8'd5);
		run_random(15);
		settle();

		idle_en = 1'b0;
		program_regs(cawb_pkg::CFG_W'($urandom_range(0, 64)),
			cawb_pkg::CFG_W'($urandom_range(0, 255)));
		run_random(15);
		settle();

		sb.finish_check();
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
